### sv/banked_memory_map_decoder_macros.svh
// assertion macros for the memory map decoder
`ifndef BANKED_MEMORY_MAP_DECODER_MACROS_SVH
`define BANKED_MEMORY_MAP_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// condition must hold in the same cycle
`define BMMD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// condition must hold in the next cycle
`define BMMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BMMD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BMMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### sv/bmmd_pkg.sv
package bmmd_pkg;

   // opcodes
   localparam logic [3:0] OP_READ       = 4'd0;
   localparam logic [3:0] OP_FETCH      = 4'd1;
   localparam logic [3:0] OP_FETCH_M1   = 4'd2;
   localparam logic [3:0] OP_WRITE      = 4'd3;
   localparam logic [3:0] OP_READ_WORD  = 4'd4;
   localparam logic [3:0] OP_WRITE_WORD = 4'd5;
   localparam logic [3:0] OP_VIDEO_MODE = 4'd6;
   localparam logic [3:0] OP_BANK_MAP   = 4'd7;
   localparam logic [3:0] OP_MEM_OPEN   = 4'd8;

   // register indexes
   localparam logic [2:0] CSR_MACHINE_MODEL  = 3'd0;
   localparam logic [2:0] CSR_MEMORY_KB      = 3'd1;
   localparam logic [2:0] CSR_BASIC_ROM_OFF  = 3'd2;
   localparam logic [2:0] CSR_DEVICE_ROM_OFF = 3'd3;
   localparam logic [2:0] CSR_LEGACY_ROM     = 3'd4;

   // regions
   localparam logic [2:0] REG_RAM       = 3'd0;
   localparam logic [2:0] REG_VIDEO     = 3'd1;
   localparam logic [2:0] REG_BASIC80   = 3'd2;
   localparam logic [2:0] REG_BASIC40   = 3'd3;
   localparam logic [2:0] REG_DEV_ROM   = 3'd4;
   localparam logic [2:0] REG_MODEL2ROM = 3'd5;

   // first model page maps
   localparam logic [2:0] MAP_BASIC80 = 3'd0;
   localparam logic [2:0] MAP_BASIC40 = 3'd1;
   localparam logic [2:0] MAP_VID30   = 3'd2;
   localparam logic [2:0] MAP_VID31   = 3'd3;
   localparam logic [2:0] MAP_VID62   = 3'd4;
   localparam logic [2:0] MAP_VID63   = 3'd5;

   localparam logic [6:0] KB_FULL = 7'd64;
   localparam logic [6:0] KB_HALF = 7'd32;

   localparam logic [15:0] K_16 = 16'h4000;
   localparam logic [15:0] K_29 = 16'h7400;
   localparam logic [15:0] K_30 = 16'h7800;
   localparam logic [15:0] K_62 = 16'hf800;

   localparam logic [5:0] PG_16 = 6'd16;
   localparam logic [5:0] PG_24 = 6'd24;
   localparam logic [5:0] PG_29 = 6'd29;
   localparam logic [5:0] PG_30 = 6'd30;
   localparam logic [5:0] PG_31 = 6'd31;
   localparam logic [5:0] PG_32 = 6'd32;
   localparam logic [5:0] PG_62 = 6'd62;
   localparam logic [5:0] PG_63 = 6'd63;

   localparam logic [15:0] CODE_MASK = 16'hf800;
   localparam logic [15:0] CODE_BASE = 16'h7800;

   typedef struct packed {
      logic [2:0]  region;
      logic [15:0] offset;
      logic        wr;
   } dec_type;

   // out-of-range sizes count as full 64k
   function automatic logic [6:0] eff_kb(input logic [6:0] kb_raw);
      logic ok;
      ok = ((kb_raw >= 7'd1) && (kb_raw <= KB_HALF)) || (kb_raw == KB_FULL);
      return ok ? kb_raw : KB_FULL;
   endfunction

   function automatic dec_type map_decode(
      input logic        model,
      input logic [6:0]  kb,
      input logic        basic_off,
      input logic        dev_off,
      input logic [2:0]  map_idx,
      input logic        area_open,
      input logic        code_map,
      input logic [15:0] addr
   );
      dec_type    d;
      logic [5:0] page;
      logic [2:0] idx;
      logic [5:0] ro_pages;
      page     = addr[15:10];
      idx      = (kb == KB_FULL) ? map_idx : {2'b00, map_idx[0]};
      ro_pages = PG_32 - kb[5:0];
      d.region = REG_RAM;
      d.offset = addr;
      d.wr     = 1'b1;
      if (!model) begin
         case (idx)
            MAP_BASIC80, MAP_BASIC40: begin
               if (page < PG_16 && !basic_off) begin
                  d.region = idx[0] ? REG_BASIC40 : REG_BASIC80;
                  d.wr     = 1'b0;
               end else if (page >= PG_16 && page < PG_32 && !dev_off) begin
                  d.region = REG_DEV_ROM;
                  d.offset = addr - K_16;
               end
               if (page == PG_29 && !idx[0]) begin
                  d.region = REG_VIDEO;
                  d.offset = addr - K_29;
                  d.wr     = 1'b1;
               end
               if (page == PG_31) begin
                  d.region = REG_VIDEO;
                  d.offset = addr - K_30;
                  d.wr     = 1'b1;
               end
               if (kb < KB_HALF && addr[15] && ({1'b0, addr[14:10]} < ro_pages)) begin
                  d.region = REG_RAM;
                  d.offset = addr;
                  d.wr     = 1'b0;
               end
            end
            MAP_VID30: begin
               if (page == PG_30 || page == PG_31) begin
                  d.region = REG_VIDEO;
                  d.offset = addr - K_30;
               end
            end
            MAP_VID31: begin
               if (page == PG_31) begin
                  d.region = REG_VIDEO;
                  d.offset = addr - K_30;
               end
            end
            MAP_VID62: begin
               if (page >= PG_62) begin
                  d.region = REG_VIDEO;
                  d.offset = addr - K_62;
               end
            end
            MAP_VID63: begin
               if (page == PG_63) begin
                  d.region = REG_VIDEO;
                  d.offset = addr - K_62;
               end
            end
            default: begin
               d.region = REG_RAM;
            end
         endcase
      end else if (!area_open) begin
         if (!code_map) begin
            if (page < PG_24 && !basic_off) begin
               d.region = REG_MODEL2ROM;
               d.wr     = 1'b0;
            end else if (page >= PG_24 && page < PG_32 && !dev_off) begin
               d.region = REG_MODEL2ROM;
               d.wr     = 1'b0;
            end
            if (page == PG_30 || page == PG_31) begin
               d.region = REG_VIDEO;
               d.offset = addr - K_30;
               d.wr     = 1'b1;
            end
         end else if (page == PG_30 || page == PG_31) begin
            d.region = REG_MODEL2ROM;
            d.wr     = 1'b0;
         end
      end
      return d;
   endfunction

endpackage

### sv/banked_memory_map_decoder.sv
// path: an item is held in the input register while it is decoded, and each byte
// result is registered in the result register, which drives rsp_ directly
// throughput: map changes one item per cycle, byte accesses too unless rsp_ stalls;
// a word holds the input register for both bytes (one decode path), as do rsp_ stalls
// reset: synchronous, active high; clears the pipeline, the map state and the
// registers to first model, 64k, roms on
`include "banked_memory_map_decoder_macros.svh"

module banked_memory_map_decoder
   import bmmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // item in
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [15:0] req_address,
   input  logic [15:0] req_data_in,
   // byte results out
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_region,
   output logic [15:0] rsp_offset,
   output logic        rsp_is_write,
   output logic        rsp_write_allowed,
   output logic [7:0]  rsp_write_byte,
   output logic        rsp_last,
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   // configuration
   logic       model_ff;
   logic [6:0] mem_kb_ff;
   logic       basic_off_ff;
   logic       dev_off_ff;

   // map state
   logic [15:0] last_m1_ff;
   logic [2:0]  map_idx_ff;
   logic        area_open_ff;

   // input register
   logic        s_valid_ff;
   logic [3:0]  s_op_ff;
   logic [15:0] s_addr_ff;
   logic [15:0] s_data_ff;
   logic        beat_ff;     // high while the high byte of a word is due

   // result register
   logic        o_valid_ff;
   logic [2:0]  o_region_ff;
   logic [15:0] o_offset_ff;
   logic        o_is_write_ff;
   logic        o_wr_ok_ff;
   logic [7:0]  o_byte_ff;
   logic        o_last_ff;

   logic        is_word;
   logic        is_write;
   logic        has_result;
   logic        out_free;
   logic        emit;
   logic        retire;
   logic [6:0]  kb;
   logic [15:0] m1_addr;
   logic        code_map;
   logic [15:0] byte_addr;
   logic [7:0]  byte_data;
   dec_type     dec;

   assign kb         = eff_kb(mem_kb_ff);
   assign is_word    = (s_op_ff == OP_READ_WORD) || (s_op_ff == OP_WRITE_WORD);
   assign is_write   = (s_op_ff == OP_WRITE) || (s_op_ff == OP_WRITE_WORD);
   assign has_result = s_op_ff inside {OP_READ, OP_FETCH, OP_FETCH_M1, OP_WRITE,
                                       OP_READ_WORD, OP_WRITE_WORD};
   assign out_free   = !o_valid_ff || rsp_ready;
   assign emit       = s_valid_ff && has_result && out_free;
   // map changes and unused opcodes leave without a result
   assign retire     = s_valid_ff && (!has_result || (emit && (!is_word || beat_ff)));
   assign req_ready  = !s_valid_ff || retire;

   // an m1 fetch already decodes against its own address
   assign m1_addr   = (s_op_ff == OP_FETCH_M1) ? s_addr_ff : last_m1_ff;
   assign code_map  = (m1_addr & CODE_MASK) == CODE_BASE;
   // second byte of a word wraps at 16 bits
   assign byte_addr = beat_ff ? (s_addr_ff + 16'd1) : s_addr_ff;
   assign byte_data = beat_ff ? s_data_ff[15:8] : s_data_ff[7:0];

   always_comb begin
      dec = map_decode(model_ff, kb, basic_off_ff, dev_off_ff, map_idx_ff,
                       area_open_ff, code_map, byte_addr);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff     <= 1'b0;
         mem_kb_ff    <= KB_FULL;
         basic_off_ff <= 1'b0;
         dev_off_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MACHINE_MODEL:  model_ff     <= csr_wdata[0];
            CSR_MEMORY_KB:      mem_kb_ff    <= csr_wdata;
            CSR_BASIC_ROM_OFF:  basic_off_ff <= csr_wdata[0];
            CSR_DEVICE_ROM_OFF: dev_off_ff   <= csr_wdata[0];
            CSR_LEGACY_ROM: begin
               // older basic image maps to the same regions, nothing to keep
            end
            default: begin
            end
         endcase
      end
   end

   // map state follows the item as it leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         last_m1_ff   <= '0;
         map_idx_ff   <= '0;
         area_open_ff <= 1'b0;
      end else if (retire) begin
         case (s_op_ff)
            OP_FETCH_M1: last_m1_ff <= s_addr_ff;
            OP_VIDEO_MODE: begin
               if (!model_ff) begin
                  map_idx_ff[0] <= (s_data_ff != 16'd0);
               end
            end
            OP_BANK_MAP: begin
               // bank select only exists with full memory
               if (!model_ff && kb == KB_FULL) begin
                  map_idx_ff[2:1] <= s_data_ff[1:0];
               end
            end
            OP_MEM_OPEN: begin
               if (model_ff) begin
                  area_open_ff <= (s_data_ff != 16'd0);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         beat_ff    <= 1'b0;
      end else begin
         if (req_ready) begin
            s_valid_ff <= req_valid;
         end
         if (retire) begin
            beat_ff <= 1'b0;
         end else if (emit && is_word) begin
            beat_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s_op_ff   <= req_opcode;
         s_addr_ff <= req_address;
         s_data_ff <= req_data_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (out_free) begin
         o_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         o_region_ff   <= dec.region;
         o_offset_ff   <= dec.offset;
         o_is_write_ff <= is_write;
         o_wr_ok_ff    <= is_write && dec.wr;
         o_byte_ff     <= is_write ? byte_data : 8'd0;
         o_last_ff     <= !is_word || beat_ff;
      end
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_region        = o_region_ff;
   assign rsp_offset        = o_offset_ff;
   assign rsp_is_write      = o_is_write_ff;
   assign rsp_write_allowed = o_wr_ok_ff;
   assign rsp_write_byte    = o_byte_ff;
   assign rsp_last          = o_last_ff;

   // checks
   `BMMD_ASSERT_NOW(a_beat_word, clock, reset, beat_ff, s_valid_ff && is_word,
                    "second beat without a word item")
   `BMMD_ASSERT_NEXT(a_word_second, clock, reset, emit && is_word && !beat_ff, beat_ff,
                     "word item lost its second byte")
   `BMMD_ASSERT_NEXT(a_beat_clear, clock, reset, emit && beat_ff, !beat_ff,
                     "second beat not cleared after word")
   `BMMD_ASSERT_NOW(a_read_clean, clock, reset, o_valid_ff && !o_is_write_ff,
                    !o_wr_ok_ff && (o_byte_ff == 8'd0), "read result carries write data")

endmodule

### test/tb.sv
module tb
   import bmmd_pkg::*;
();

   // clocking, reset and run length
   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 9;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_CYCLES     = 240;
   localparam int MISMATCH_REPORT = 10;

   // stimulus shape
   localparam int PHASE_COUNT     = 11;
   localparam int ITEMS_PER_PHASE = 72;
   localparam int PRESSURE_PHASE  = 8;

   // index with no register behind it, opcodes with no meaning
   localparam logic [2:0] CSR_UNUSED  = 3'd7;
   localparam logic [3:0] OP_SPARE_LO = 4'd9;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   // one byte result as it appears on the rsp_ channel
   typedef struct packed {
      logic [2:0]  region;
      logic [15:0] offset;
      logic        is_write;
      logic        write_allowed;
      logic [7:0]  write_byte;
      logic        last;
   } byte_result_type;

   // one register setting of the decoder
   typedef struct packed {
      logic       model;
      logic [6:0] kb;
      logic       basic_off;
      logic       dev_off;
      logic       legacy_rom;
   } map_setting_type;

   // predicts the byte results of every accepted item and checks them in order
   class map_scoreboard_type;
      // register copy
      logic        model;
      logic [6:0]  kb_raw;
      logic        basic_off;
      logic        dev_off;
      logic        legacy_rom;
      // map state copy
      logic [15:0] m1_addr;
      logic [2:0]  map_sel;
      logic        area_open;
      byte_result_type pending_bytes[$];
      int items_seen;
      int words_seen;
      int map_changes;
      int bytes_checked;
      int mismatches;

      function new();
         model      = 1'b0;
         kb_raw     = KB_FULL;
         basic_off  = 1'b0;
         dev_off    = 1'b0;
         legacy_rom = 1'b0;
         m1_addr    = '0;
         map_sel    = '0;
         area_open  = 1'b0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [6:0] val);
         case (idx)
            CSR_MACHINE_MODEL:  model      = val[0];
            CSR_MEMORY_KB:      kb_raw     = val;
            CSR_BASIC_ROM_OFF:  basic_off  = val[0];
            CSR_DEVICE_ROM_OFF: dev_off    = val[0];
            CSR_LEGACY_ROM:     legacy_rom = val[0];
            default: ;
         endcase
      endfunction

      // sizes outside 1..32 other than 64 behave as full memory
      function int unsigned size_in_use();
         if ((kb_raw < 7'd1 || kb_raw > 7'd32) && kb_raw != 7'd64)
            return 64;
         return kb_raw;
      endfunction

      function byte_result_type map_byte(logic [15:0] addr, logic wr, logic [7:0] wbyte,
                                         logic lastb);
         int unsigned     a;
         int unsigned     page;
         int unsigned     kb;
         logic [2:0]      sel;
         logic [2:0]      rgn;
         logic [15:0]     off;
         logic            ok;
         logic            code_run;
         byte_result_type r;
         a        = addr;
         page     = a / 1024;
         rgn      = REG_RAM;
         off      = addr;
         ok       = 1'b1;
         code_run = ((m1_addr & CODE_MASK) == CODE_BASE);
         if (!model) begin
            kb  = size_in_use();
            sel = map_sel;
            if (kb != 64)
               sel = {2'b00, sel[0]};
            case (sel)
               MAP_BASIC80, MAP_BASIC40: begin
                  if (page < 16 && !basic_off) begin
                     rgn = sel[0] ? REG_BASIC40 : REG_BASIC80;
                     ok  = 1'b0;
                  end else if (page >= 16 && page < 32 && !dev_off) begin
                     rgn = REG_DEV_ROM;
                     off = 16'(a - 16 * 1024);
                  end
                  if (page == 29 && sel == MAP_BASIC80) begin
                     rgn = REG_VIDEO;
                     off = 16'(a - 29 * 1024);
                     ok  = 1'b1;
                  end
                  if (page == 31) begin
                     rgn = REG_VIDEO;
                     off = 16'(a - 30 * 1024);
                     ok  = 1'b1;
                  end
                  if (kb < 32 && a >= 32 * 1024 && a < (64 - kb) * 1024) begin
                     rgn = REG_RAM;
                     off = addr;
                     ok  = 1'b0;
                  end
               end
               MAP_VID30: begin
                  if (page == 30 || page == 31) begin
                     rgn = REG_VIDEO;
                     off = 16'(a - 30 * 1024);
                  end
               end
               MAP_VID31: begin
                  if (page == 31) begin
                     rgn = REG_VIDEO;
                     off = 16'(a - 30 * 1024);
                  end
               end
               MAP_VID62: begin
                  if (page >= 62) begin
                     rgn = REG_VIDEO;
                     off = 16'(a - 62 * 1024);
                  end
               end
               MAP_VID63: begin
                  if (page == 63) begin
                     rgn = REG_VIDEO;
                     off = 16'(a - 62 * 1024);
                  end
               end
               default: ;
            endcase
         end else if (!area_open && !code_run) begin
            if (page < 24 && !basic_off) begin
               rgn = REG_MODEL2ROM;
               ok  = 1'b0;
            end else if (page >= 24 && page < 32 && !dev_off) begin
               rgn = REG_MODEL2ROM;
               ok  = 1'b0;
            end
            if (page == 30 || page == 31) begin
               rgn = REG_VIDEO;
               off = 16'(a - 30 * 1024);
               ok  = 1'b1;
            end
         end else if (!area_open) begin
            if (page == 30 || page == 31) begin
               rgn = REG_MODEL2ROM;
               ok  = 1'b0;
            end
         end
         r.region        = rgn;
         r.offset        = off;
         r.is_write      = wr;
         r.write_allowed = wr & ok;
         r.write_byte    = wr ? wbyte : 8'h00;
         r.last          = lastb;
         return r;
      endfunction

      function void note_input(logic [3:0] op, logic [15:0] addr, logic [15:0] data);
         items_seen++;
         case (op)
            OP_READ, OP_FETCH:
               pending_bytes.push_back(map_byte(addr, 1'b0, 8'h00, 1'b1));
            OP_FETCH_M1: begin
               m1_addr = addr;
               pending_bytes.push_back(map_byte(addr, 1'b0, 8'h00, 1'b1));
            end
            OP_WRITE:
               pending_bytes.push_back(map_byte(addr, 1'b1, data[7:0], 1'b1));
            OP_READ_WORD: begin
               words_seen++;
               pending_bytes.push_back(map_byte(addr, 1'b0, 8'h00, 1'b0));
               pending_bytes.push_back(map_byte(addr + 16'd1, 1'b0, 8'h00, 1'b1));
            end
            OP_WRITE_WORD: begin
               words_seen++;
               pending_bytes.push_back(map_byte(addr, 1'b1, data[7:0], 1'b0));
               pending_bytes.push_back(map_byte(addr + 16'd1, 1'b1, data[15:8], 1'b1));
            end
            OP_VIDEO_MODE: begin
               map_changes++;
               if (!model)
                  map_sel[0] = (data != 16'd0);
            end
            OP_BANK_MAP: begin
               map_changes++;
               if (!model && size_in_use() == 64)
                  map_sel[2:1] = data[1:0];
            end
            OP_MEM_OPEN: begin
               map_changes++;
               if (model)
                  area_open = (data != 16'd0);
            end
            default: ;
         endcase
      endfunction

      function void report_mismatch(string what, byte_result_type want,
                                    byte_result_type got);
         mismatches++;
         if (mismatches <= MISMATCH_REPORT) begin
            $display("%0t: %s: expected region %0d offset %h wr %b ok %b byte %h last %b",
                     $realtime, what, want.region, want.offset, want.is_write,
                     want.write_allowed, want.write_byte, want.last);
            $display("%0t: %s: actual   region %0d offset %h wr %b ok %b byte %h last %b",
                     $realtime, what, got.region, got.offset, got.is_write,
                     got.write_allowed, got.write_byte, got.last);
         end
      endfunction

      function void check_result(byte_result_type got);
         byte_result_type want;
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            report_mismatch("byte result with no item outstanding", '0, got);
            return;
         end
         want = pending_bytes.pop_front();
         if (got.region !== want.region || got.offset !== want.offset ||
             got.is_write !== want.is_write || got.write_allowed !== want.write_allowed ||
             got.write_byte !== want.write_byte || got.last !== want.last)
            report_mismatch("byte result mismatch", want, got);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_opcode;
   logic [15:0] req_address;
   logic [15:0] req_data_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_region;
   logic [15:0] rsp_offset;
   logic        rsp_is_write;
   logic        rsp_write_allowed;
   logic [7:0]  rsp_write_byte;
   logic        rsp_last;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [6:0]  csr_wdata;

   map_scoreboard_type sb;

   // idling percentages, read by the sender task and the receiver process
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   // one long hold-off on the result side, requested by the main sequence
   logic        hold_request = 1'b0;
   int          holds_done = 0;
   // raw size of the current setting, steers addresses toward the read-only edge
   logic [6:0]  cur_kb = KB_FULL;
   int          settings_done = 0;
   int          cycle_count = 0;

   banked_memory_map_decoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_address       (req_address),
      .req_data_in       (req_data_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_region        (rsp_region),
      .rsp_offset        (rsp_offset),
      .rsp_is_write      (rsp_is_write),
      .rsp_write_allowed (rsp_write_allowed),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // both handshakes are sampled here, before anything driven at this edge lands;
   // the item is noted first, its results cannot come back in the same cycle anyway
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_input(req_opcode, req_address, req_data_in);
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_region, rsp_offset, rsp_is_write, rsp_write_allowed,
                             rsp_write_byte, rsp_last});
      end
   end

   // result side: random stalls, plus the long hold-off that backs the block up
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0d cycles without finishing, %0d byte results still outstanding",
               cycle_count, sb.pending_bytes.size());
      $display("CHECK FAILED");
      $finish;
   end

   // offer one item, with a random gap in front, and hold it until accepted
   task automatic offer_item(input logic [3:0] op, input logic [15:0] addr,
                             input logic [15:0] data);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_address <= addr;
      req_data_in <= data;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // stop offering, let the last accepted item be noted, then let every
   // outstanding byte come back; map changes leave nothing to wait for, so a
   // final drain wait covers one still in flight
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [6:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   // one-bit registers get random upper bits, which the block must ignore
   task automatic apply_setting(input map_setting_type s);
      write_csr(CSR_MACHINE_MODEL, {6'($urandom), s.model});
      write_csr(CSR_MEMORY_KB, s.kb);
      write_csr(CSR_BASIC_ROM_OFF, {6'($urandom), s.basic_off});
      write_csr(CSR_DEVICE_ROM_OFF, {6'($urandom), s.dev_off});
      write_csr(CSR_LEGACY_ROM, {6'($urandom), s.legacy_rom});
      write_csr(CSR_UNUSED, 7'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
      cur_kb = s.kb;
      settings_done++;
   endtask

   // settings: both models, size extremes, sizes that fall back to 64k, rom flags
   function automatic map_setting_type setting_for(int ph);
      case (ph)
         0:       return '{1'b0, 7'd64,  1'b0, 1'b0, 1'b0};
         1:       return '{1'b0, 7'd1,   1'b0, 1'b0, 1'b1};
         2:       return '{1'b0, 7'd31,  1'b1, 1'b0, 1'b0};
         3:       return '{1'b0, 7'd32,  1'b0, 1'b1, 1'b0};
         4:       return '{1'b0, 7'd0,   1'b1, 1'b1, 1'b1};
         5:       return '{1'b1, 7'd64,  1'b0, 1'b0, 1'b0};
         6:       return '{1'b1, 7'd16,  1'b1, 1'b0, 1'b1};
         7:       return '{1'b1, 7'd127, 1'b0, 1'b1, 1'b0};
         8:       return '{1'b0, 7'd24,  1'b0, 1'b0, 1'b0};
         9:       return '{1'b0, 7'd33,  1'b0, 1'b0, 1'b1};
         default: return '{1'b1, 7'd1,   1'b1, 1'b1, 1'b1};
      endcase
   endfunction

   // addresses lean on page edges of the interesting pages, the top byte, the
   // code window and the edge of the read-only area of small memories
   function automatic logic [15:0] pick_address();
      int unsigned s;
      int unsigned pg;
      logic [9:0]  low;
      s = $urandom_range(9);
      if (s < 4)
         return 16'($urandom);
      if (s == 8)
         return 16'hffff;
      if (s == 9)
         return CODE_BASE | 16'($urandom_range(2047));
      case ($urandom_range(2))
         0:       low = 10'h000;
         1:       low = 10'h3ff;
         default: low = 10'($urandom);
      endcase
      if (s == 7 && cur_kb >= 7'd1 && cur_kb < 7'd32)
         pg = 63 - cur_kb + $urandom_range(1);
      else
         case ($urandom_range(13))
            0:       pg = 0;
            1:       pg = 15;
            2:       pg = 16;
            3:       pg = 23;
            4:       pg = 24;
            5:       pg = 28;
            6:       pg = 29;
            7:       pg = 30;
            8:       pg = 31;
            9:       pg = 32;
            10:      pg = 47;
            11:      pg = 61;
            12:      pg = 62;
            default: pg = 63;
         endcase
      return {6'(pg), low};
   endfunction

   task automatic make_random_item(output logic [3:0] op, output logic [15:0] addr,
                                   output logic [15:0] data);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 22)      op = OP_READ;
      else if (r < 32) op = OP_FETCH;
      else if (r < 44) op = OP_FETCH_M1;
      else if (r < 60) op = OP_WRITE;
      else if (r < 70) op = OP_READ_WORD;
      else if (r < 80) op = OP_WRITE_WORD;
      else if (r < 85) op = OP_VIDEO_MODE;
      else if (r < 90) op = OP_BANK_MAP;
      else if (r < 96) op = OP_MEM_OPEN;
      else             op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      addr = pick_address();
      // at least half the m1 fetches land in the code window
      if (op == OP_FETCH_M1 && $urandom_range(1) == 0)
         addr = CODE_BASE | 16'($urandom_range(2047));
      data = 16'($urandom);
      // mode and open operands: zero half the time, otherwise often a lone bit
      if ((op == OP_VIDEO_MODE || op == OP_MEM_OPEN) && $urandom_range(1) == 0)
         data = 16'd0;
      else if ((op == OP_VIDEO_MODE || op == OP_MEM_OPEN) && $urandom_range(1) == 0)
         data = 16'd1 << $urandom_range(15);
   endtask

   initial begin
      int          ph;
      int          sent;
      logic [3:0]  op;
      logic [15:0] addr;
      logic [15:0] data;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = '0;
      req_address = '0;
      req_data_in = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items on the reset setting: first model, 64k, roms in
      tx_idle_pct = 38;
      rx_idle_pct = 56;
      offer_item(OP_READ,       16'h0000, 16'h0000);   // bottom of basic rom
      offer_item(OP_FETCH,      16'h3fff, 16'hffff);   // last basic rom byte
      offer_item(OP_WRITE,      16'h4000, 16'h00a5);   // device rom is writable
      offer_item(OP_READ,       16'h7400, 16'h0000);   // first video k, 80 columns
      offer_item(OP_READ,       16'h7bff, 16'h0000);   // page 30 stays device rom
      offer_item(OP_WRITE,      16'h7c00, 16'hff5a);   // second video k
      offer_item(OP_WRITE_WORD, 16'hffff, 16'hbeef);   // word wraps to address zero
      offer_item(OP_READ_WORD,  16'h3fff, 16'h0000);   // word across rom edge
      offer_item(OP_WRITE,      16'h0010, 16'h0033);   // write to basic rom dropped
      offer_item(OP_VIDEO_MODE, 16'h0000, 16'h8000);   // nonzero only in the top bit
      offer_item(OP_READ,       16'h7400, 16'h0000);   // 40 columns: no video at 29
      offer_item(OP_READ,       16'h0000, 16'h0000);   // 40-column basic rom
      offer_item(OP_BANK_MAP,   16'h0000, 16'h0001);   // video at 31k only
      offer_item(OP_READ_WORD,  16'h7bff, 16'h0000);
      offer_item(OP_VIDEO_MODE, 16'hffff, 16'h0000);   // video at 30k-32k
      offer_item(OP_READ,       16'h7800, 16'h0000);
      offer_item(OP_BANK_MAP,   16'h0000, 16'h0002);   // video at 62k-64k
      offer_item(OP_WRITE_WORD, 16'hf7ff, 16'h1234);
      offer_item(OP_BANK_MAP,   16'h0000, 16'h0003);   // all ram
      offer_item(OP_READ,       16'h0000, 16'h0000);
      offer_item(OP_MEM_OPEN,   16'h0000, 16'h0001);   // wrong model, ignored
      offer_item(OP_SPARE_HI,   16'h1234, 16'h5678);   // unused opcode
      offer_item(OP_FETCH_M1,   16'h7800, 16'h0000);   // m1 into the code window
      offer_item(OP_BANK_MAP,   16'h0000, 16'hfffc);   // only low two bits count
      offer_item(OP_READ,       16'hffff, 16'h0000);

      // random phases, one register setting each; idling pattern moves along
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph < 4) begin
            tx_idle_pct = 38;
            rx_idle_pct = 56;
         end else if (ph < PRESSURE_PHASE) begin
            tx_idle_pct = 56;
            rx_idle_pct = 38;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         wait_quiet();
         apply_setting(setting_for(ph));
         if (ph == PRESSURE_PHASE)
            hold_request = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            make_random_item(op, addr, data);
            offer_item(op, addr, data);
            // only accesses count, map changes and unused opcodes ride along
            if (op <= OP_WRITE_WORD)
               sent++;
         end
      end

      wait_quiet();
      $display("ran %0d items (%0d word accesses, %0d map changes) over %0d settings",
               sb.items_seen, sb.words_seen, sb.map_changes, settings_done);
      $display("checked %0d byte results, %0d long output stalls, %0d mismatches",
               sb.bytes_checked, holds_done, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
